/* src/gbe_pkg.sv */
// Shared types, codes and defaults for the gap buffer engine.
package gbe_pkg;

  // Fixed field widths of the request and result beats.
  localparam int POS_W = 11;
  localparam int VAL_W = 8;
  localparam int LEN_W = 11;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  // Default sizing of the element store.
  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_ELEM_WIDTH = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LEFT = 3'd3;
  localparam logic [OP_W-1:0] OP_MOVE     = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // Request beat.
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] write_value;
  } gbe_in_t;

  // Result beat.
  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
    logic [ST_W-1:0]  status;
  } gbe_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request
    logic latch_st;    // capture the request status
    logic walk_rd;     // read the element that crosses the gap
    logic walk_wr;     // write it on the far side and step the gap
    logic jump;        // empty gap: set the gap position directly
    logic apply;       // perform the operation's final update
    logic rd_issue;    // read the addressed element for a read request
    logic rd_capture;  // capture the read data into the result
  } gbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;         // request is refused
    logic is_read;     // request is a read
    logic at_target;   // gap already sits at the requested index
    logic gap_empty;   // store is full, the gap has no slots
  } gbe_sts_t;

endpackage

/* src/gbe_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/gbe_datapath.sv */
// Datapath of the gap buffer engine: request registers, gap and length counters, element store.
module gbe_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int ELEM_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gbe_pkg::gbe_in_t  in_data,
  input  gbe_pkg::gbe_cmd_t cmd,
  output gbe_pkg::gbe_sts_t sts,
  output gbe_pkg::gbe_out_t out_data
);
  import gbe_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // Request and result registers.
  logic [OP_W-1:0]       op_r;
  logic [POS_W-1:0]      pos_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [VAL_W-1:0]      rd_r;
  logic [ST_W-1:0]       st_r;

  // Gap position and element count.
  logic [CW-1:0] gap_r, gap_nxt;
  logic [CW-1:0] used_r, used_nxt;

  logic [XW-1:0]         pos_x, used_x;
  logic [CW-1:0]         target, free_slots;
  logic                  move_left;
  logic [ST_W-1:0]       st_calc;
  logic [CW-1:0]         src_addr, dst_addr, phys_addr;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

  assign pos_x      = XW'(pos_r);
  assign used_x     = XW'(used_r);
  assign target     = CW'(pos_x);
  assign free_slots = CAP_C - used_r;
  assign move_left  = target < gap_r;

  // Range and capacity checks of the held request.
  always_comb begin
    st_calc = ST_OK;
    case (op_r)
      OP_READ: begin
        if (pos_x >= used_x) st_calc = ST_BAD_INDEX;
      end
      OP_INSERT: begin
        if (pos_x > used_x) st_calc = ST_BAD_INDEX;
        else if (used_r == CAP_C) st_calc = ST_FULL;
      end
      OP_DEL_AT: begin
        if (pos_x >= used_x) st_calc = ST_BAD_INDEX;
      end
      OP_DEL_LEFT: begin
        if (pos_x == '0 || pos_x > used_x) st_calc = ST_BAD_INDEX;
      end
      OP_MOVE: begin
        if (pos_x > used_x) st_calc = ST_BAD_INDEX;
      end
      default: st_calc = ST_BAD_INDEX;
    endcase
  end

  assign sts.bad       = (st_calc != ST_OK);
  assign sts.is_read   = (op_r == OP_READ);
  assign sts.at_target = (gap_r == target);
  assign sts.gap_empty = (used_r == CAP_C);

  // Physical slots of one gap step and of a logical read.
  assign src_addr  = move_left ? (gap_r - ONE_C) : (gap_r + free_slots);
  assign dst_addr  = move_left ? (gap_r - ONE_C + free_slots) : gap_r;
  assign phys_addr = move_left ? target : (target + free_slots);

  // Store port selection.
  always_comb begin
    ram_re    = cmd.walk_rd || cmd.rd_issue;
    ram_raddr = cmd.rd_issue ? AW'(phys_addr) : AW'(src_addr);
    ram_we    = 1'b0;
    ram_waddr = AW'(dst_addr);
    ram_wdata = ram_rdata;
    if (cmd.walk_wr) begin
      ram_we = 1'b1;
    end else if (cmd.apply && op_r == OP_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(gap_r);
      ram_wdata = val_r;
    end
  end

  gbe_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next gap position and element count.
  always_comb begin
    gap_nxt  = gap_r;
    used_nxt = used_r;
    if (cmd.jump) begin
      gap_nxt = target;
    end else if (cmd.walk_wr) begin
      gap_nxt = move_left ? (gap_r - ONE_C) : (gap_r + ONE_C);
    end else if (cmd.apply) begin
      case (op_r)
        OP_INSERT: begin
          gap_nxt  = gap_r + ONE_C;
          used_nxt = used_r + ONE_C;
        end
        OP_DEL_AT: begin
          used_nxt = used_r - ONE_C;
        end
        OP_DEL_LEFT: begin
          gap_nxt  = gap_r - ONE_C;
          used_nxt = used_r - ONE_C;
        end
        default: begin
          gap_nxt  = gap_r;
          used_nxt = used_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      used_r <= '0;
    end else begin
      gap_r  <= gap_nxt;
      used_r <= used_nxt;
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.operation;
      pos_r <= in_data.position;
      val_r <= ELEM_WIDTH'(in_data.write_value);
      rd_r  <= '0;
    end else if (cmd.rd_capture) begin
      rd_r <= VAL_W'(ram_rdata);
    end
    if (cmd.latch_st) begin
      st_r <= st_calc;
    end
  end

  assign out_data.read_value = rd_r;
  assign out_data.length     = LEN_W'(used_r);
  assign out_data.status     = st_r;

endmodule

/* src/gbe_ctrl.sv */
// Controller state machine of the gap buffer engine.
module gbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gbe_pkg::gbe_sts_t sts,
  output gbe_pkg::gbe_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import gbe_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_WALK_WR = 3'd2;
  localparam logic [2:0] S_APPLY   = 3'd3;
  localparam logic [2:0] S_RD_WAIT = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.latch_st = 1'b1;
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.is_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RD_WAIT;
        end else if (sts.at_target) begin
          state_nxt = S_APPLY;
        end else if (sts.gap_empty) begin
          cmd.jump  = 1'b1;
          state_nxt = S_APPLY;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

/* src/gap_buffer_engine.sv */
// Top level of the gap buffer engine: controller plus datapath.
//
//   channel   ports                       direction  handshake
//   request   start, busy, in_data        in         start && !busy takes the beat
//   result    out_valid, out_data         out        one-cycle strobe, always taken
//
// An accepted request passes S_CHECK and then S_APPLY or S_RD_WAIT, and its result beat
// comes in S_DONE; a refused request goes from S_CHECK straight to S_DONE.
// Each element the gap crosses on its way to the index adds an S_CHECK read and an
// S_WALK_WR write, as the store's read data is registered. busy is high from the
// accepting edge through the result cycle; S_IDLE then takes the next request beat.
// Reset (rst_n low, synchronous) empties the buffer; the result receiver cannot stall.
module gap_buffer_engine #(
  parameter int CAPACITY   = gbe_pkg::DEF_CAPACITY,
  parameter int ELEM_WIDTH = gbe_pkg::DEF_ELEM_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  gbe_pkg::gbe_in_t in_data,
  output logic             out_valid,
  output gbe_pkg::gbe_out_t out_data
);
  import gbe_pkg::*;

  gbe_cmd_t cmd;
  gbe_sts_t sts;

  // Sequencing of each request.
  gbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Counters, checks and the element store.
  gbe_datapath #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
